>>> hw/rtl/cnew_pkg.sv
// constants and helper functions for the cpio newc entry walker
`timescale 1ns / 1ps

package cnew_pkg;

  localparam int unsigned MagicLen        = 6;
  localparam int unsigned GapBeforeSize   = 48;
  localparam int unsigned GapBeforeName   = 32;
  localparam int unsigned HexDigits       = 8;
  localparam int unsigned HeaderLen       = 110;
  localparam int unsigned TrailerLen      = 10;
  localparam int unsigned SizeAt          = MagicLen + GapBeforeSize;
  localparam int unsigned NameSizeAt      = SizeAt + HexDigits + GapBeforeName;

  localparam int unsigned HdrCountW       = 7;
  localparam int unsigned TrailerIdxW     = 4;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_digit_t;

  // ascii hex digit, upper or lower case; anything else is zero and flagged
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.bad   = 1'b0;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.value = 4'(c - 8'h57);
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

  // characters of the end-of-archive name
  function automatic logic [7:0] trailer_char(input logic [TrailerIdxW-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h54; // T
      4'd1:    ch = 8'h52; // R
      4'd2:    ch = 8'h41; // A
      4'd3:    ch = 8'h49; // I
      4'd4:    ch = 8'h4C; // L
      4'd5:    ch = 8'h45; // E
      4'd6:    ch = 8'h52; // R
      4'd7:    ch = 8'h21; // !
      4'd8:    ch = 8'h21; // !
      4'd9:    ch = 8'h21; // !
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> hw/rtl/cpio_newc_entry_walker.sv
// cpio newc archive walker: strips headers and padding, emits name and content bytes
`timescale 1ns / 1ps

// Takes one archive byte per cycle and gives at most one result per byte, in the
// cycle after the byte is taken, through a single output register. Each byte
// is handled by counter, compare and hex-decode logic in the cycle it is
// accepted, so in_ready stays high as long as the output register is empty or
// being emptied in the same cycle; a full rate of one byte per clock holds
// across header, padding, name and content. Header bytes, the name terminator
// and alignment padding are consumed without a result. The 8-digit file size
// and name size fields accept 0-9, A-F and a-f; any other character reads as
// zero and raises header_error on the entry's results. After the entry named
// TRAILER!!! has been fully consumed, all further bytes are taken and dropped
// until reset.
module cpio_newc_entry_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  archive_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        region,
  output logic [7:0]  out_byte,
  output logic [31:0] position,
  output logic        last_of_region,
  output logic [31:0] entry_file_size,
  output logic        is_trailer,
  output logic        header_error
);

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_NAME     = 3'd1,
    PH_NAME_PAD = 3'd2,
    PH_DATA     = 3'd3,
    PH_DATA_PAD = 3'd4
  } phase_t;

  localparam logic [cnew_pkg::HdrCountW-1:0] HdrLast =
    cnew_pkg::HdrCountW'(cnew_pkg::HeaderLen - 1);
  localparam logic [cnew_pkg::HdrCountW-1:0] SizeLo =
    cnew_pkg::HdrCountW'(cnew_pkg::SizeAt);
  localparam logic [cnew_pkg::HdrCountW-1:0] SizeHi =
    cnew_pkg::HdrCountW'(cnew_pkg::SizeAt + cnew_pkg::HexDigits);
  localparam logic [cnew_pkg::HdrCountW-1:0] NameLo =
    cnew_pkg::HdrCountW'(cnew_pkg::NameSizeAt);
  localparam logic [cnew_pkg::HdrCountW-1:0] NameHi =
    cnew_pkg::HdrCountW'(cnew_pkg::NameSizeAt + cnew_pkg::HexDigits);
  localparam logic [1:0]  HdrLenLow   = 2'(cnew_pkg::HeaderLen);
  localparam logic [31:0] TrailerName = 32'(cnew_pkg::TrailerLen + 1);
  localparam logic [31:0] TrailerEnd  = 32'(cnew_pkg::TrailerLen - 1);

  typedef struct packed {
    phase_t phase;
    logic   restart;
    logic   finish;
  } adv_t;

  phase_t                         phase, phase_next;
  logic [cnew_pkg::HdrCountW-1:0] header_count, header_count_next;
  logic [31:0]                    size_accum, size_accum_next;
  logic [31:0]                    name_accum, name_accum_next;
  logic [31:0]                    region_count, region_count_next;
  logic                           trailer_match, trailer_match_next;
  logic                           bad_hex, bad_hex_next;
  logic                           finished, finished_next;

  logic        in_accept;
  logic        emit;
  logic        res_region, res_last, res_trailer;
  logic        do_adv;
  adv_t        adv;
  cnew_pkg::hex_digit_t           hd;
  logic [cnew_pkg::HdrCountW-1:0] hc_inc;
  logic [1:0]  name_pad, data_pad;
  logic        match;

  // next non-empty part of the entry after the part just finished
  function automatic adv_t advance(input phase_t done, input logic [31:0] nsz,
                                   input logic [31:0] fsz, input logic tm);
    adv_t a;
    logic [1:0] npad;
    logic [1:0] dpad;
    npad      = 2'd0 - (HdrLenLow + nsz[1:0]);
    dpad      = 2'd0 - fsz[1:0];
    a.phase   = PH_HEADER;
    a.restart = 1'b0;
    a.finish  = 1'b0;
    if (done < PH_NAME && nsz != 32'd0) begin
      a.phase = PH_NAME;
    end else if (done < PH_NAME_PAD && npad != 2'd0) begin
      a.phase = PH_NAME_PAD;
    end else if (done < PH_DATA && fsz != 32'd0) begin
      a.phase = PH_DATA;
    end else if (done < PH_DATA_PAD && dpad != 2'd0) begin
      a.phase = PH_DATA_PAD;
    end else if (tm && nsz == TrailerName) begin
      a.finish = 1'b1;
    end else begin
      a.restart = 1'b1;
    end
    return a;
  endfunction

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign hd       = cnew_pkg::hex_decode(archive_byte);
  assign hc_inc   = header_count + cnew_pkg::HdrCountW'(1);
  assign name_pad = 2'd0 - (HdrLenLow + name_accum[1:0]);
  assign data_pad = 2'd0 - size_accum[1:0];
  assign match    = trailer_match && region_count < 32'(cnew_pkg::TrailerLen) &&
                    archive_byte ==
                    cnew_pkg::trailer_char(region_count[cnew_pkg::TrailerIdxW-1:0]);
  // the size fields are complete before the last header byte, so the stored
  // values are the ones to look at whenever a part ends
  assign adv      = advance(phase, name_accum, size_accum, trailer_match);

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    size_accum_next    = size_accum;
    name_accum_next    = name_accum;
    region_count_next  = region_count;
    trailer_match_next = trailer_match;
    bad_hex_next       = bad_hex;
    finished_next      = finished;
    emit               = 1'b0;
    res_region         = 1'b0;
    res_last           = 1'b0;
    res_trailer        = 1'b0;
    do_adv             = 1'b0;

    if (in_accept && !finished) begin
      unique case (phase)
        PH_HEADER: begin
          if (header_count >= SizeLo && header_count < SizeHi) begin
            size_accum_next = {size_accum[27:0], hd.value};
            bad_hex_next    = bad_hex | hd.bad;
          end else if (header_count >= NameLo && header_count < NameHi) begin
            name_accum_next = {name_accum[27:0], hd.value};
            bad_hex_next    = bad_hex | hd.bad;
          end
          header_count_next = hc_inc;
          do_adv            = header_count >= HdrLast;
        end
        PH_NAME: begin
          region_count_next = region_count + 32'd1;
          if (region_count >= name_accum - 32'd1) begin
            // terminator byte, dropped
            do_adv = 1'b1;
          end else begin
            emit               = 1'b1;
            res_last           = region_count == name_accum - 32'd2;
            trailer_match_next = match;
            res_trailer        = res_last ? (match && region_count == TrailerEnd) : match;
          end
        end
        PH_NAME_PAD: begin
          header_count_next = hc_inc;
          do_adv            = hc_inc >= cnew_pkg::HdrCountW'(name_pad);
        end
        PH_DATA: begin
          region_count_next = region_count + 32'd1;
          emit              = 1'b1;
          res_region        = 1'b1;
          res_last          = region_count == size_accum - 32'd1;
          do_adv            = res_last;
        end
        PH_DATA_PAD: begin
          header_count_next = hc_inc;
          do_adv            = hc_inc >= cnew_pkg::HdrCountW'(data_pad);
        end
        default: begin
          phase_next         = PH_HEADER;
          header_count_next  = '0;
          size_accum_next    = '0;
          name_accum_next    = '0;
          region_count_next  = '0;
          trailer_match_next = 1'b1;
          bad_hex_next       = 1'b0;
        end
      endcase

      if (do_adv) begin
        if (adv.finish) begin
          finished_next = 1'b1;
        end else if (adv.restart) begin
          phase_next         = PH_HEADER;
          header_count_next  = '0;
          size_accum_next    = '0;
          name_accum_next    = '0;
          region_count_next  = '0;
          trailer_match_next = 1'b1;
          bad_hex_next       = 1'b0;
        end else begin
          phase_next = adv.phase;
          if (adv.phase == PH_NAME || adv.phase == PH_DATA) begin
            region_count_next = '0;
          end else begin
            header_count_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_count  <= '0;
      size_accum    <= '0;
      name_accum    <= '0;
      region_count  <= '0;
      trailer_match <= 1'b1;
      bad_hex       <= 1'b0;
      finished      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      size_accum    <= size_accum_next;
      name_accum    <= name_accum_next;
      region_count  <= region_count_next;
      trailer_match <= trailer_match_next;
      bad_hex       <= bad_hex_next;
      finished      <= finished_next;
      if (in_ready) begin
        out_valid <= emit;
      end
      // result register, loaded only with a transaction that produces output
      if (emit) begin
        region          <= res_region;
        out_byte        <= archive_byte;
        position        <= region_count;
        last_of_region  <= res_last;
        entry_file_size <= size_accum;
        is_trailer      <= res_trailer;
        header_error    <= bad_hex;
      end
    end
  end

endmodule

>>> tb/cpio_newc_entry_walker_test.sv
// testbench for the cpio newc entry walker: builds archives, predicts and checks every result
`timescale 1ns / 1ps

module cpio_newc_entry_walker_test;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_NAME_PAD,
    PH_DATA,
    PH_DATA_PAD
  } walk_phase_t;

  typedef struct packed {
    logic        region;
    logic [7:0]  data;
    logic [31:0] pos;
    logic        last;
    logic [31:0] fsize;
    logic        trailer;
    logic        herr;
  } walk_result_t;

  localparam logic [47:0] MAGIC_TEXT   = "070701";
  localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";
  localparam logic        REGION_NAME  = 1'b0;
  localparam logic        REGION_DATA  = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  archive_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        region;
  logic [7:0]  out_byte;
  logic [31:0] position;
  logic        last_of_region;
  logic [31:0] entry_file_size;
  logic        is_trailer;
  logic        header_error;

  cpio_newc_entry_walker DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .archive_byte    (archive_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .region          (region),
    .out_byte        (out_byte),
    .position        (position),
    .last_of_region  (last_of_region),
    .entry_file_size (entry_file_size),
    .is_trailer      (is_trailer),
    .header_error    (header_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  walk_phase_t walk_ph;
  logic [6:0]  hdr_cnt;
  logic [31:0] fsize_acc;
  logic [31:0] nsize_acc;
  logic [31:0] reg_cnt;
  logic        trl_match;
  logic        hex_bad;
  logic        walk_done;

  walk_result_t pending_out[$];
  walk_result_t oldest_out;
  logic [7:0]   name_chars[$];

  int fail_count = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    if (c >= "0" && c <= "9") begin
      t = c - "0";
    end else if (c >= "A" && c <= "F") begin
      t = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      t = c - "a" + 8'd10;
    end else begin
      return 5'h10;
    end
    return {1'b0, t[3:0]};
  endfunction

  function automatic logic [7:0] trailer_letter(input logic [31:0] p);
    if (p >= cnew_pkg::TrailerLen) return 8'h00;
    return TRAILER_TEXT[79 - 8 * p -: 8];
  endfunction

  function automatic logic [31:0] name_pad();
    return (32'd4 - ((32'(cnew_pkg::HeaderLen) + nsize_acc) & 32'd3)) & 32'd3;
  endfunction

  function automatic logic [31:0] data_pad();
    return (32'd4 - (fsize_acc & 32'd3)) & 32'd3;
  endfunction

  task automatic start_header();
    walk_ph   = PH_HEADER;
    hdr_cnt   = 7'd0;
    fsize_acc = 32'd0;
    nsize_acc = 32'd0;
    reg_cnt   = 32'd0;
    trl_match = 1'b1;
    hex_bad   = 1'b0;
  endtask

  // skip to the next part of the entry that has any bytes
  task automatic next_part(input walk_phase_t done);
    if (done < PH_NAME && nsize_acc != 0) begin
      walk_ph = PH_NAME;
      reg_cnt = 32'd0;
    end else if (done < PH_NAME_PAD && name_pad() != 0) begin
      walk_ph = PH_NAME_PAD;
      hdr_cnt = 7'd0;
    end else if (done < PH_DATA && fsize_acc != 0) begin
      walk_ph = PH_DATA;
      reg_cnt = 32'd0;
    end else if (done < PH_DATA_PAD && data_pad() != 0) begin
      walk_ph = PH_DATA_PAD;
      hdr_cnt = 7'd0;
    end else if (trl_match && nsize_acc == cnew_pkg::TrailerLen + 1) begin
      walk_done = 1'b1;
    end else begin
      start_header();
    end
  endtask

  task automatic walk_byte(input logic [7:0] b);
    logic [31:0]  p;
    logic [6:0]   c;
    logic [4:0]   d;
    logic         last;
    logic         match;
    walk_result_t r;
    if (walk_done) return;
    case (walk_ph)
      PH_HEADER: begin
        c = hdr_cnt;
        if (c >= cnew_pkg::SizeAt && c < cnew_pkg::SizeAt + cnew_pkg::HexDigits) begin
          d = hex_digit(b);
          hex_bad = hex_bad | d[4];
          fsize_acc = {fsize_acc[27:0], d[3:0]};
        end else if (c >= cnew_pkg::NameSizeAt &&
                     c < cnew_pkg::NameSizeAt + cnew_pkg::HexDigits) begin
          d = hex_digit(b);
          hex_bad = hex_bad | d[4];
          nsize_acc = {nsize_acc[27:0], d[3:0]};
        end
        hdr_cnt = c + 7'd1;
        if (32'(c) + 1 >= cnew_pkg::HeaderLen) next_part(PH_HEADER);
      end
      PH_NAME: begin
        p = reg_cnt;
        reg_cnt = p + 32'd1;
        if (p >= nsize_acc - 32'd1) begin
          // terminator slot, value not looked at
          next_part(PH_NAME);
        end else begin
          last = (p == nsize_acc - 32'd2);
          match = trl_match && (p < cnew_pkg::TrailerLen) && (b == trailer_letter(p));
          trl_match = match;
          r.region  = REGION_NAME;
          r.data    = b;
          r.pos     = p;
          r.last    = last;
          r.fsize   = fsize_acc;
          r.trailer = last ? (match && p == cnew_pkg::TrailerLen - 1) : match;
          r.herr    = hex_bad;
          pending_out.push_back(r);
        end
      end
      PH_NAME_PAD: begin
        hdr_cnt = hdr_cnt + 7'd1;
        if (32'(hdr_cnt) >= name_pad()) next_part(PH_NAME_PAD);
      end
      PH_DATA: begin
        p = reg_cnt;
        reg_cnt = p + 32'd1;
        last = (p == fsize_acc - 32'd1);
        r.region  = REGION_DATA;
        r.data    = b;
        r.pos     = p;
        r.last    = last;
        r.fsize   = fsize_acc;
        r.trailer = 1'b0;
        r.herr    = hex_bad;
        pending_out.push_back(r);
        if (last) next_part(PH_DATA);
      end
      PH_DATA_PAD: begin
        hdr_cnt = hdr_cnt + 7'd1;
        if (32'(hdr_cnt) >= data_pad()) next_part(PH_DATA_PAD);
      end
      default: begin
        start_header();
      end
    endcase
  endtask

  // one archive byte, with random idle cycles in front of it
  task automatic push_archive_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    archive_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    walk_byte(b);
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
  endtask

  // ascii digit in random case, or a random non-hex character
  function automatic logic [7:0] digit_char(input logic [3:0] v, input logic bad);
    logic [7:0] c;
    logic [4:0] d;
    if (bad) begin
      do begin
        c = 8'($urandom);
        d = hex_digit(c);
      end while (!d[4]);
      return c;
    end
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(1) ? "a" : "A") + v - 8'd10;
  endfunction

  task automatic load_name(input string s);
    int i;
    name_chars.delete();
    for (i = 0; i < s.len(); i++) name_chars.push_back(s[i]);
  endtask

  // bad_mask marks digits to spoil: [15:8] file size, [7:0] name size, msb digit first
  task automatic send_entry(input logic [31:0] name_len, input logic [31:0] content_len,
                            input logic [15:0] bad_mask, input logic [7:0] nul_byte);
    logic [31:0] nsz;
    logic [31:0] fsz;
    logic [31:0] pad;
    logic [7:0]  b;
    logic        magic_ok;
    int          i;
    int          k;
    nsz = name_len;
    fsz = content_len;
    for (k = 0; k < 8; k++) begin
      if (bad_mask[15 - k]) fsz[31 - 4 * k -: 4] = 4'd0;
      if (bad_mask[7 - k]) nsz[31 - 4 * k -: 4] = 4'd0;
    end
    magic_ok = ($urandom_range(99) < 80);
    for (i = 0; i < cnew_pkg::HeaderLen; i++) begin
      if (i < cnew_pkg::MagicLen && magic_ok) begin
        b = MAGIC_TEXT[47 - 8 * i -: 8];
      end else if (i >= cnew_pkg::SizeAt && i < cnew_pkg::SizeAt + cnew_pkg::HexDigits) begin
        b = digit_char(content_len[31 - 4 * (i - cnew_pkg::SizeAt) -: 4],
                       bad_mask[15 - (i - cnew_pkg::SizeAt)]);
      end else if (i >= cnew_pkg::NameSizeAt &&
                   i < cnew_pkg::NameSizeAt + cnew_pkg::HexDigits) begin
        b = digit_char(name_len[31 - 4 * (i - cnew_pkg::NameSizeAt) -: 4],
                       bad_mask[7 - (i - cnew_pkg::NameSizeAt)]);
      end else begin
        b = 8'($urandom);
      end
      push_archive_byte(b);
    end
    if (nsz != 0) begin
      for (i = 0; i + 1 < nsz; i++) begin
        b = (i < name_chars.size()) ? name_chars[i] : 8'($urandom);
        push_archive_byte(b);
      end
      push_archive_byte(nul_byte);
    end
    pad = (32'd4 - ((32'(cnew_pkg::HeaderLen) + nsz) & 32'd3)) & 32'd3;
    for (i = 0; i < pad; i++) push_archive_byte(8'($urandom));
    for (i = 0; i < fsz; i++) push_archive_byte(8'($urandom));
    pad = (32'd4 - (fsz & 32'd3)) & 32'd3;
    for (i = 0; i < pad; i++) push_archive_byte(8'($urandom));
  endtask

  task automatic test_plain_entries();
    load_name("hello.txt");
    send_entry(32'd10, 32'd5, 16'h0000, 8'h00);
    name_chars.delete();
    send_entry(32'd0, 32'd0, 16'h0000, 8'h00);
    send_entry(32'd0, 32'd3, 16'h0000, 8'h00);
    send_entry(32'd1, 32'd7, 16'h0000, 8'h00);
  endtask

  task automatic test_hex_fields();
    name_chars.delete();
    send_entry(32'h1d, 32'h0b, 16'h0000, 8'h00);
    // spoiled digits read as zero and flag the header
    send_entry(32'h13, 32'h2b, 16'h8181, 8'h00);
  endtask

  task automatic test_name_bytes();
    load_name("ab");
    name_chars.push_back(8'h00);
    name_chars.push_back("c");
    name_chars.push_back(8'hff);
    send_entry(32'd6, 32'd2, 16'h0000, 8'hff);
    load_name("TRAIL");
    name_chars.push_back(8'h00);
    name_chars.push_back("R");
    name_chars.push_back("!");
    name_chars.push_back("!");
    name_chars.push_back("!");
    send_entry(32'd11, 32'd1, 16'h0000, 8'h00);
  endtask

  task automatic test_near_trailer();
    load_name("TRAILER!!");
    send_entry(32'd10, 32'd2, 16'h0000, 8'h00);
    load_name("TRAILER!!!X");
    send_entry(32'd12, 32'd0, 16'h0000, 8'h00);
    load_name("TRAILER!!?");
    send_entry(32'd11, 32'd0, 16'h0000, 8'h00);
  endtask

  // every name padding and content padding length
  task automatic test_padding();
    int n;
    name_chars.delete();
    for (n = 2; n <= 5; n++) begin
      send_entry(n, n - 1, 16'h0000, 8'h00);
      if (n == 3) drain_pending();
    end
  endtask

  task automatic test_random_archive(input int send_pct, input int stall_pct);
    int          start;
    int          kind;
    int          k;
    logic [31:0] nsz;
    logic [31:0] fsz;
    logic [15:0] mask;
    logic [7:0]  nul;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < 150) begin
      kind = $urandom_range(99);
      name_chars.delete();
      if (kind < 10) begin
        nsz = 32'd0;
      end else if (kind < 22) begin
        // trailer name with one letter changed
        load_name("TRAILER!!!");
        k = $urandom_range(cnew_pkg::TrailerLen - 1);
        name_chars[k] = name_chars[k] ^ 8'($urandom_range(255, 1));
        nsz = cnew_pkg::TrailerLen + 1;
      end else if (kind < 30) begin
        // prefixes of the trailer name and names running past it
        load_name("TRAILER!!!");
        nsz = $urandom_range(14, 1);
        if (nsz == cnew_pkg::TrailerLen + 1) nsz = cnew_pkg::TrailerLen + 2;
      end else begin
        nsz = $urandom_range(24, 1);
      end
      k = $urandom_range(99);
      if (k < 75) fsz = $urandom_range(12, 0);
      else if (k < 95) fsz = $urandom_range(64, 13);
      else fsz = $urandom_range(300, 65);
      mask = ($urandom_range(99) < 15) ? (16'($urandom) & 16'($urandom)) : 16'h0000;
      nul = ($urandom_range(99) < 80) ? 8'h00 : 8'($urandom);
      send_entry(nsz, fsz, mask, nul);
      if ($urandom_range(99) < 5) drain_pending();
    end
  endtask

  // the end entry, then bytes that must all be swallowed
  task automatic test_trailer_end();
    int i;
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    load_name("TRAILER!!!");
    send_entry(cnew_pkg::TrailerLen + 1, 32'd6, 16'h0000, "X");
    for (i = 0; i < 40; i++) push_archive_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got byte %h", $time, out_byte);
        fail_count++;
      end else begin
        oldest_out = pending_out.pop_front();
        check_field("region", oldest_out.region, region);
        check_field("out_byte", oldest_out.data, out_byte);
        check_field("position", oldest_out.pos, position);
        check_field("last_of_region", oldest_out.last, last_of_region);
        check_field("entry_file_size", oldest_out.fsize, entry_file_size);
        check_field("is_trailer", oldest_out.trailer, is_trailer);
        check_field("header_error", oldest_out.herr, header_error);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL cpio_newc_entry_walker");
    $finish;
  end

  initial begin
    walk_done = 1'b0;
    start_header();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // no idling
    test_plain_entries();
    test_hex_fields();
    // sender idle
    send_idle_pct  = 54;
    recv_stall_pct = 0;
    test_name_bytes();
    test_near_trailer();
    // receiver stalling
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    test_padding();
    // both
    test_random_archive(15, 15);
    test_trailer_end();
    drain_pending();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS cpio_newc_entry_walker");
    end else begin
      $display("FAIL cpio_newc_entry_walker");
    end
    $finish;
  end

endmodule

>>> cpio_newc_entry_walker.f
hw/rtl/cnew_pkg.sv
hw/rtl/cpio_newc_entry_walker.sv
tb/cpio_newc_entry_walker_test.sv
